@@ design/rdl_pkg.sv @@
// Shared constants, types and state codes of the resampling delay line.
package rdl_pkg;

   // Ring geometry and field widths.
   localparam int ENTRIES = 16;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int LEFT_W = IDX_W + 1;
   localparam int VAL_W = 32;
   localparam int TIME_W = 24;
   localparam int TOTAL_W = TIME_W + 1;
   localparam int NUM_W = TIME_W + 2;
   localparam int DIFF_W = VAL_W + 1;
   localparam int PROD_W = DIFF_W + NUM_W;
   localparam int DIV_N_W = PROD_W + 1;
   localparam int DIV_D_W = TIME_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   localparam logic [TIME_W-1:0] STEP_RESET = 24'd131072;
   localparam logic [TIME_W-1:0] OFFSET_EPS = 24'd105;

   // Transaction kinds.
   localparam logic KIND_RESTART = 1'b0;
   localparam logic KIND_ADD = 1'b1;

   // Ring memory access for one cycle.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [VAL_W-1:0] wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   // Divider start request and result.
   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] numer;
      logic [DIV_D_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quot;
      logic [DIV_D_W-1:0] remd;
   } div_rsp_type;

   // Sequencer states.
   typedef enum logic [15:0] {
      S_CLEAR    = 16'h0001,
      S_IDLE     = 16'h0002,
      S_FILL     = 16'h0004,
      S_CNT      = 16'h0008,
      S_CNT_WAIT = 16'h0010,
      S_ADD_END  = 16'h0020,
      S_RD       = 16'h0040,
      S_RD_NEW   = 16'h0080,
      S_RD_OWAIT = 16'h0100,
      S_RD_OLD   = 16'h0200,
      S_RD_A     = 16'h0400,
      S_RD_B     = 16'h0800,
      S_L_MUL    = 16'h1000,
      S_L_DIV    = 16'h2000,
      S_L_WAIT   = 16'h4000,
      S_DONE     = 16'h8000
   } state_type;

endpackage

@@ design/rdl_channels.sv @@
// Valid/ready channel interfaces for requests and responses.
interface rdl_req_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic signed [rdl_pkg::VAL_W-1:0]   sample_value;
   logic [rdl_pkg::TIME_W-1:0]         elapsed_time;
   logic [rdl_pkg::TIME_W-1:0]         query_delay;

   modport source (output valid, kind, sample_value, elapsed_time, query_delay,
                   input ready);
   modport sink (input valid, kind, sample_value, elapsed_time, query_delay,
                 output ready);
endinterface

interface rdl_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rdl_pkg::VAL_W-1:0]   delayed_value;

   modport source (output valid, delayed_value, input ready);
   modport sink (input valid, delayed_value, output ready);
endinterface

@@ design/rdl_ring_mem.sv @@
// Ring sample memory with one write port and one registered read port.
module rdl_ring_mem (
   input  logic                        clock,
   input  rdl_pkg::mem_req_type        mem_req,
   output logic [rdl_pkg::VAL_W-1:0]   rd_data
);

   logic [rdl_pkg::VAL_W-1:0] ring_ff [rdl_pkg::ENTRIES];
   logic [rdl_pkg::VAL_W-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         ring_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= ring_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/rdl_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module rdl_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rdl_pkg::div_req_type div_req,
   output rdl_pkg::div_rsp_type div_rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [rdl_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [rdl_pkg::DIV_N_W-1:0]        quot_ff, quot_in;
   logic [rdl_pkg::DIV_D_W:0]          rem_ff, rem_in;
   logic [rdl_pkg::DIV_D_W-1:0]        den_ff, den_in;
   logic [rdl_pkg::DIV_D_W:0]          trial;
   logic                               fits;

   // Shift in the next numerator bit and try a subtraction.
   assign trial = {rem_ff[rdl_pkg::DIV_D_W-1:0], quot_ff[rdl_pkg::DIV_N_W-1]};
   assign fits = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         quot_in = div_req.numer;
         rem_in = '0;
         den_in = div_req.denom;
      end else if (busy_ff) begin
         rem_in = fits ? trial - {1'b0, den_ff} : trial;
         quot_in = {quot_ff[rdl_pkg::DIV_N_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rdl_pkg::DIV_CNT_W'(rdl_pkg::DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.remd = rem_ff[rdl_pkg::DIV_D_W-1:0];

endmodule

@@ design/resampling_delay_line.sv @@
// Top level of the resampling delay line: sequencer around ring memory and divider.
//
//   channel   dir  handshake       payload
//   req_chan  in   valid/ready     kind, sample_value, elapsed_time, query_delay
//   rsp_chan  out  valid/ready     delayed_value
//   csr       in   csr_wr_en       csr_wr_data (step_period)
//
// One transaction at a time; the shared divider sets the pace.
// Restart: 16 ring writes plus the read. Add: one division for the step
// count plus one interpolation per ring write (at most 16), then the read.
// A read costs up to one division and one interpolation.
// After reset a clearing pass zeroes the ring; req_chan.ready is low.
// The result waits in an output register, so a stalled response never blocks
// acceptance of the next request.
module resampling_delay_line (
   input  logic                        clock,
   input  logic                        reset,
   rdl_req_if.sink                     req_chan,
   rdl_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [rdl_pkg::TIME_W-1:0]  csr_wr_data
);

   rdl_pkg::state_type                 state_ff, state_in;
   logic [rdl_pkg::TIME_W-1:0]         step_ff, step_in, step_eff;
   logic [rdl_pkg::IDX_W-1:0]          cursor_ff, cursor_in;
   logic [rdl_pkg::TIME_W-1:0]         off_ff, off_in;
   logic [rdl_pkg::VAL_W-1:0]          last_ff, last_in;
   logic [rdl_pkg::VAL_W-1:0]          sample_ff, sample_in;
   logic [rdl_pkg::TIME_W-1:0]         dt_ff, dt_in;
   logic [rdl_pkg::TIME_W-1:0]         delay_ff, delay_in;
   logic [rdl_pkg::IDX_W-1:0]          cnt_lo_ff, cnt_lo_in;
   logic [rdl_pkg::LEFT_W-1:0]         wr_left_ff, wr_left_in;
   logic [rdl_pkg::IDX_W-1:0]          wr_idx_ff, wr_idx_in;
   logic [rdl_pkg::IDX_W-1:0]          o_ff, o_in;
   logic [rdl_pkg::VAL_W-1:0]          lerp_a_ff, lerp_a_in;
   logic [rdl_pkg::VAL_W-1:0]          lerp_b_ff, lerp_b_in;
   logic signed [rdl_pkg::NUM_W-1:0]   lerp_num_ff, lerp_num_in;
   logic [rdl_pkg::TIME_W-1:0]         lerp_den_ff, lerp_den_in;
   logic                               to_mem_ff, to_mem_in;
   logic signed [rdl_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic                               neg_ff, neg_in;
   logic [rdl_pkg::VAL_W-1:0]          result_ff, result_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rdl_pkg::VAL_W-1:0]          rsp_data_ff, rsp_data_in;

   rdl_pkg::mem_req_type               mem_req;
   logic [rdl_pkg::VAL_W-1:0]          mem_rd_data;
   rdl_pkg::div_req_type               div_req;
   rdl_pkg::div_rsp_type               div_rsp;

   logic [rdl_pkg::TOTAL_W-1:0]        total;
   logic signed [rdl_pkg::DIFF_W-1:0]  diff;
   logic [rdl_pkg::TOTAL_W-1:0]        den2;
   logic signed [rdl_pkg::DIV_N_W-1:0] p_full;
   logic [rdl_pkg::DIV_N_W-1:0]        p_mag;
   logic [rdl_pkg::DIV_N_W-1:0]        quot_s;
   logic [rdl_pkg::VAL_W-1:0]          lerp_res;
   logic [rdl_pkg::LEFT_W-1:0]         n_writes;

   rdl_ring_mem u_ring_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   rdl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // A zero step period behaves as one.
   assign step_eff = (step_ff == '0) ? rdl_pkg::TIME_W'(1) : step_ff;
   assign total = rdl_pkg::TOTAL_W'(dt_ff) + rdl_pkg::TOTAL_W'(off_ff);

   // Interpolation datapath: p = 2*(b-a)*num + den, floor-divided by 2*den.
   assign diff = $signed({lerp_b_ff[rdl_pkg::VAL_W-1], lerp_b_ff})
               - $signed({lerp_a_ff[rdl_pkg::VAL_W-1], lerp_a_ff});
   assign den2 = {lerp_den_ff, 1'b0};
   assign p_full = $signed({prod_ff, 1'b0})
                 + $signed(rdl_pkg::DIV_N_W'(lerp_den_ff));
   assign p_mag = p_full[rdl_pkg::DIV_N_W-1]
                ? (rdl_pkg::DIV_N_W'(-p_full) + rdl_pkg::DIV_N_W'(den2)
                   - rdl_pkg::DIV_N_W'(1))
                : rdl_pkg::DIV_N_W'(p_full);
   assign quot_s = neg_ff ? -div_rsp.quot : div_rsp.quot;
   assign lerp_res = lerp_a_ff + quot_s[rdl_pkg::VAL_W-1:0];

   // Only the last ENTRIES ring writes of one add are performed.
   assign n_writes = (div_rsp.quot > rdl_pkg::DIV_N_W'(rdl_pkg::ENTRIES))
                   ? rdl_pkg::LEFT_W'(rdl_pkg::ENTRIES)
                   : div_rsp.quot[rdl_pkg::LEFT_W-1:0];

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      step_in = csr_wr_en ? csr_wr_data : step_ff;
      cursor_in = cursor_ff;
      off_in = off_ff;
      last_in = last_ff;
      sample_in = sample_ff;
      dt_in = dt_ff;
      delay_in = delay_ff;
      cnt_lo_in = cnt_lo_ff;
      wr_left_in = wr_left_ff;
      wr_idx_in = wr_idx_ff;
      o_in = o_ff;
      lerp_a_in = lerp_a_ff;
      lerp_b_in = lerp_b_ff;
      lerp_num_in = lerp_num_ff;
      lerp_den_in = lerp_den_ff;
      to_mem_in = to_mem_ff;
      prod_in = prod_ff;
      neg_in = neg_ff;
      result_in = result_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_data_in = rsp_data_ff;
      mem_req = '0;
      div_req = '0;

      unique case (state_ff)
         rdl_pkg::S_CLEAR: begin
            mem_req.wr_en = 1'b1;
            mem_req.wr_addr = wr_idx_ff;
            mem_req.wr_data = '0;
            wr_idx_in = wr_idx_ff + 1'b1;
            if (wr_idx_ff == rdl_pkg::IDX_W'(rdl_pkg::ENTRIES - 1)) begin
               state_in = rdl_pkg::S_IDLE;
            end
         end
         rdl_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               sample_in = req_chan.sample_value;
               dt_in = req_chan.elapsed_time;
               delay_in = req_chan.query_delay;
               if (req_chan.kind == rdl_pkg::KIND_RESTART) begin
                  cursor_in = '0;
                  off_in = '0;
                  last_in = req_chan.sample_value;
                  wr_idx_in = '0;
                  state_in = rdl_pkg::S_FILL;
               end else begin
                  state_in = rdl_pkg::S_CNT;
               end
            end
         end
         rdl_pkg::S_FILL: begin
            mem_req.wr_en = 1'b1;
            mem_req.wr_addr = wr_idx_ff;
            mem_req.wr_data = last_ff;
            wr_idx_in = wr_idx_ff + 1'b1;
            if (wr_idx_ff == rdl_pkg::IDX_W'(rdl_pkg::ENTRIES - 1)) begin
               state_in = rdl_pkg::S_RD;
            end
         end
         rdl_pkg::S_CNT: begin
            div_req.start = 1'b1;
            div_req.numer = rdl_pkg::DIV_N_W'(total);
            div_req.denom = rdl_pkg::DIV_D_W'(step_eff);
            state_in = rdl_pkg::S_CNT_WAIT;
         end
         rdl_pkg::S_CNT_WAIT: begin
            if (div_rsp.done) begin
               // Writes run from the newest step backward.
               cnt_lo_in = div_rsp.quot[rdl_pkg::IDX_W-1:0];
               off_in = div_rsp.remd[rdl_pkg::TIME_W-1:0];
               wr_left_in = n_writes;
               wr_idx_in = cursor_ff + div_rsp.quot[rdl_pkg::IDX_W-1:0];
               lerp_a_in = last_ff;
               lerp_b_in = sample_ff;
               lerp_num_in = $signed(rdl_pkg::NUM_W'(dt_ff))
                           - $signed(rdl_pkg::NUM_W'(div_rsp.remd));
               lerp_den_in = dt_ff;
               to_mem_in = 1'b1;
               state_in = (n_writes == '0) ? rdl_pkg::S_ADD_END : rdl_pkg::S_L_MUL;
            end
         end
         rdl_pkg::S_ADD_END: begin
            cursor_in = cursor_ff + cnt_lo_ff;
            last_in = sample_ff;
            state_in = rdl_pkg::S_RD;
         end
         rdl_pkg::S_RD: begin
            if (delay_ff <= off_ff) begin
               if (off_ff < rdl_pkg::OFFSET_EPS) begin
                  result_in = last_ff;
                  state_in = rdl_pkg::S_DONE;
               end else begin
                  mem_req.rd_en = 1'b1;
                  mem_req.rd_addr = cursor_ff;
                  state_in = rdl_pkg::S_RD_NEW;
               end
            end else begin
               div_req.start = 1'b1;
               div_req.numer = rdl_pkg::DIV_N_W'(delay_ff - off_ff);
               div_req.denom = rdl_pkg::DIV_D_W'(step_eff);
               state_in = rdl_pkg::S_RD_OWAIT;
            end
         end
         rdl_pkg::S_RD_NEW: begin
            // Between the newest ring entry and the last raw sample.
            lerp_a_in = mem_rd_data;
            lerp_b_in = last_ff;
            lerp_num_in = $signed(rdl_pkg::NUM_W'(off_ff - delay_ff));
            lerp_den_in = off_ff;
            to_mem_in = 1'b0;
            state_in = rdl_pkg::S_L_MUL;
         end
         rdl_pkg::S_RD_OWAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quot >= rdl_pkg::DIV_N_W'(rdl_pkg::ENTRIES - 1)) begin
                  mem_req.rd_en = 1'b1;
                  mem_req.rd_addr = cursor_ff - rdl_pkg::IDX_W'(rdl_pkg::ENTRIES - 1);
                  state_in = rdl_pkg::S_RD_OLD;
               end else begin
                  o_in = div_rsp.quot[rdl_pkg::IDX_W-1:0];
                  mem_req.rd_en = 1'b1;
                  mem_req.rd_addr = cursor_ff - div_rsp.quot[rdl_pkg::IDX_W-1:0]
                                  - rdl_pkg::IDX_W'(1);
                  lerp_num_in = $signed(rdl_pkg::NUM_W'(step_eff))
                              - $signed(rdl_pkg::NUM_W'(div_rsp.remd));
                  lerp_den_in = step_eff;
                  to_mem_in = 1'b0;
                  state_in = rdl_pkg::S_RD_A;
               end
            end
         end
         rdl_pkg::S_RD_OLD: begin
            result_in = mem_rd_data;
            state_in = rdl_pkg::S_DONE;
         end
         rdl_pkg::S_RD_A: begin
            lerp_a_in = mem_rd_data;
            mem_req.rd_en = 1'b1;
            mem_req.rd_addr = cursor_ff - o_ff;
            state_in = rdl_pkg::S_RD_B;
         end
         rdl_pkg::S_RD_B: begin
            lerp_b_in = mem_rd_data;
            state_in = rdl_pkg::S_L_MUL;
         end
         rdl_pkg::S_L_MUL: begin
            prod_in = diff * lerp_num_ff;
            state_in = rdl_pkg::S_L_DIV;
         end
         rdl_pkg::S_L_DIV: begin
            div_req.start = 1'b1;
            div_req.numer = p_mag;
            div_req.denom = rdl_pkg::DIV_D_W'(den2);
            neg_in = p_full[rdl_pkg::DIV_N_W-1];
            state_in = rdl_pkg::S_L_WAIT;
         end
         rdl_pkg::S_L_WAIT: begin
            if (div_rsp.done) begin
               if (to_mem_ff) begin
                  mem_req.wr_en = 1'b1;
                  mem_req.wr_addr = wr_idx_ff;
                  mem_req.wr_data = lerp_res;
                  wr_idx_in = wr_idx_ff - 1'b1;
                  lerp_num_in = lerp_num_ff - $signed(rdl_pkg::NUM_W'(step_eff));
                  wr_left_in = wr_left_ff - 1'b1;
                  state_in = (wr_left_ff == rdl_pkg::LEFT_W'(1))
                           ? rdl_pkg::S_ADD_END : rdl_pkg::S_L_MUL;
               end else begin
                  result_in = lerp_res;
                  state_in = rdl_pkg::S_DONE;
               end
            end
         end
         rdl_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = result_ff;
               state_in = rdl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rdl_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdl_pkg::S_CLEAR;
         step_ff <= rdl_pkg::STEP_RESET;
         cursor_ff <= '0;
         off_ff <= '0;
         last_ff <= '0;
         wr_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         cursor_ff <= cursor_in;
         off_ff <= off_in;
         last_ff <= last_in;
         wr_idx_ff <= wr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff <= sample_in;
      dt_ff <= dt_in;
      delay_ff <= delay_in;
      cnt_lo_ff <= cnt_lo_in;
      wr_left_ff <= wr_left_in;
      o_ff <= o_in;
      lerp_a_ff <= lerp_a_in;
      lerp_b_ff <= lerp_b_in;
      lerp_num_ff <= lerp_num_in;
      lerp_den_ff <= lerp_den_in;
      to_mem_ff <= to_mem_in;
      prod_ff <= prod_in;
      neg_ff <= neg_in;
      result_ff <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready = (state_ff == rdl_pkg::S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.delayed_value = rsp_data_ff;

endmodule

@@ design/rdl_checker.sv @@
// Port-level checker for the resampling delay line, bound to the top level.
module rdl_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rdl_pkg::VAL_W-1:0]  rsp_data
);

   logic [1:0] pending_ff, pending_in;

   // Transactions accepted whose response is not yet taken.
   always_comb begin
      pending_in = pending_ff + 2'((req_valid && req_ready) ? 1 : 0)
                 - 2'((rsp_valid && rsp_ready) ? 1 : 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A response is only shown for an accepted request.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without a pending request");

   // One request at a time: acceptance drops ready for the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // The clearing pass after reset holds off requests.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or valid right after reset");

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind resampling_delay_line rdl_checker u_rdl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.delayed_value)
);
